// ===== hdl/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
package deq_pkg;

    localparam int KEY_W = 32;
    localparam int AGE_W = 8;
    localparam int PRI_W = 4;
    localparam int SRV_W = 8;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [SRV_W-1:0] SRV_MAX = 8'hFF;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [PRI_W-1:0] priority_val;
        logic [SRV_W-1:0] served;
    } t_rec;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
    } t_cell_cmd;

endpackage

// ===== hdl/deq_cell.sv =====
// One storage cell of the queue chain; cell 0 holds the front entry.
module deq_cell
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int INDEX = 0
) (
    input  logic                       i_clk,
    input  t_cell_cmd                  i_cmd,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  t_rec                       i_rec,
    input  t_rec                       i_left,
    input  t_rec                       i_right,
    output t_rec                       o_data,
    output t_rec                       o_back_tap,
    output logic [PRI_W-1:0]           o_prev_tap
);
    localparam int CW = $clog2(DEPTH+1);
    localparam logic HAS_PREV = (INDEX + 2 <= DEPTH);

    t_rec r_data;
    logic is_last;
    logic is_prev;

    assign is_last = (i_count == CW'(INDEX + 1));
    assign is_prev = HAS_PREV && (i_count == CW'(INDEX + 2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_front) begin
            r_data <= i_left;
        end else if (i_cmd.pop_front) begin
            r_data <= i_right;
        end else if (i_cmd.push_back && (i_count == CW'(INDEX))) begin
            r_data <= i_rec;
        end
    end

    assign o_data     = r_data;
    assign o_back_tap = is_last ? r_data : '0;
    assign o_prev_tap = is_prev ? r_data.priority_val : '0;

endmodule

// ===== hdl/double_ended_queue.sv =====
// Top level of the double-ended queue: a shifting chain of entry cells.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-----------------------------------
//   input   | i_in_valid  | o_in_stall  | i_operation, i_entry_*
//   output  | o_out_valid | i_out_stall | o_status, o_popped_*, o_front_*,
//           |             |             | o_back_*, o_entry_count
//
// The chain shifts or writes one cell at the accepting edge and the result is
// registered at that same edge, so one item per cycle is sustained while the
// output is not stalled. The back entry is found by a compare of each cell index
// with the count. Synchronous reset empties the queue and clears o_out_valid.
// An item is refused only while a result waits and the output is stalled.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [OP_W-1:0]            i_operation,
    input  logic [KEY_W-1:0]           i_entry_key,
    input  logic [AGE_W-1:0]           i_entry_age,
    input  logic [PRI_W-1:0]           i_entry_priority,
    input  logic [SRV_W-1:0]           i_entry_served,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ST_W-1:0]            o_status,
    output logic [KEY_W-1:0]           o_popped_key,
    output logic [AGE_W-1:0]           o_popped_age,
    output logic [PRI_W-1:0]           o_popped_priority,
    output logic [SRV_W-1:0]           o_popped_served,
    output logic [PRI_W-1:0]           o_front_priority,
    output logic                       o_front_valid,
    output logic [PRI_W-1:0]           o_back_priority,
    output logic                       o_back_valid,
    output logic [$clog2(DEPTH+1)-1:0] o_entry_count
);
    localparam int CW = $clog2(DEPTH+1);

    t_rec              rec;
    t_cell_cmd         cmd;
    t_rec              w_data [DEPTH];
    t_rec              w_back [DEPTH];
    logic [PRI_W-1:0]  w_prev [DEPTH];
    t_rec              back_rec;
    logic [PRI_W-1:0]  prev_pri;

    logic              accept;
    logic              empty;
    logic              full;
    logic              is_push_f;
    logic              is_push_b;
    logic              is_pop_f;
    logic              is_pop_b;
    logic              push_f_ok;
    logic              push_b_ok;
    logic              pop_f_ok;
    logic              pop_b_ok;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [ST_W-1:0]   n_status;
    t_rec              r_popped;
    t_rec              n_popped;
    logic [PRI_W-1:0]  r_front_pri;
    logic [PRI_W-1:0]  n_front_pri;
    logic [PRI_W-1:0]  r_back_pri;
    logic [PRI_W-1:0]  n_back_pri;
    logic              r_nonempty;
    logic [CW-1:0]     r_out_count;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    assign rec.key          = i_entry_key;
    assign rec.age          = i_entry_age;
    assign rec.priority_val = i_entry_priority;
    assign rec.served       = (i_entry_served == SRV_MAX) ? SRV_MAX
                                                          : i_entry_served + 8'd1;

    assign empty     = (r_count == '0);
    assign full      = (r_count == CW'(DEPTH));
    assign is_push_f = (i_operation == OP_PUSH_FRONT);
    assign is_push_b = (i_operation == OP_PUSH_BACK);
    assign is_pop_f  = (i_operation == OP_POP_FRONT);
    assign is_pop_b  = (i_operation == OP_POP_BACK);
    assign push_f_ok = is_push_f && !full;
    assign push_b_ok = is_push_b && !full;
    assign pop_f_ok  = is_pop_f && !empty;
    assign pop_b_ok  = is_pop_b && !empty;

    assign cmd.push_front = accept && push_f_ok;
    assign cmd.push_back  = accept && push_b_ok;
    assign cmd.pop_front  = accept && pop_f_ok;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_rec left_in;
        t_rec right_in;
        if (g == 0) begin : g_first
            assign left_in = rec;
        end else begin : g_mid_l
            assign left_in = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_in = w_data[g];
        end else begin : g_mid_r
            assign right_in = w_data[g+1];
        end
        deq_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_count    (r_count),
            .i_rec      (rec),
            .i_left     (left_in),
            .i_right    (right_in),
            .o_data     (w_data[g]),
            .o_back_tap (w_back[g]),
            .o_prev_tap (w_prev[g])
        );
    end

    // At most one cell drives each tap, so an OR merges them.
    always_comb begin
        back_rec = '0;
        prev_pri = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_rec = back_rec | w_back[i];
            prev_pri = prev_pri | w_prev[i];
        end
    end

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_popped    = '0;
        n_front_pri = w_data[0].priority_val;
        n_back_pri  = back_rec.priority_val;
        if ((is_push_f || is_push_b) && full) begin
            n_status = ST_FULL;
        end else if ((is_pop_f || is_pop_b) && empty) begin
            n_status = ST_EMPTY;
        end else if (push_f_ok) begin
            n_count     = r_count + 1'b1;
            n_front_pri = rec.priority_val;
            if (empty) begin
                n_back_pri = rec.priority_val;
            end
        end else if (push_b_ok) begin
            n_count    = r_count + 1'b1;
            n_back_pri = rec.priority_val;
            if (empty) begin
                n_front_pri = rec.priority_val;
            end
        end else if (pop_f_ok) begin
            n_count     = r_count - 1'b1;
            n_popped    = w_data[0];
            n_front_pri = w_data[1].priority_val;
        end else if (pop_b_ok) begin
            n_count    = r_count - 1'b1;
            n_popped   = back_rec;
            n_back_pri = prev_pri;
        end
        if (n_count == '0) begin
            n_front_pri = '0;
            n_back_pri  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_popped    <= n_popped;
            r_front_pri <= n_front_pri;
            r_back_pri  <= n_back_pri;
            r_nonempty  <= (n_count != '0);
            r_out_count <= n_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_popped_key      = r_popped.key;
    assign o_popped_age      = r_popped.age;
    assign o_popped_priority = r_popped.priority_val;
    assign o_popped_served   = r_popped.served;
    assign o_front_priority  = r_front_pri;
    assign o_front_valid     = r_nonempty;
    assign o_back_priority   = r_back_pri;
    assign o_back_valid      = r_nonempty;
    assign o_entry_count     = r_out_count;

endmodule
